### sv/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, codes and helpers of the tridiagonal system solver.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int IDX_W = 6;
  localparam int CFG_W = 17;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROW0,
    OP_MUL_U,
    OP_SUB_U,
    OP_MUL_R,
    OP_SUB_R,
    OP_DIV,
    OP_WRITE,
    OP_BS_RD,
    OP_BS_MUL,
    OP_BS_SUB,
    OP_EM_RD,
    OP_EM_OUT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] addr;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } sat_t;

  function automatic sat_t sub_sat(input logic signed [31:0] x, input logic signed [31:0] y);
    logic signed [32:0] s;
    sat_t r;
    s = {x[31], x} - {y[31], y};
    r.sat = (s[32] != s[31]);
    r.val = r.sat ? (s[32] ? Q_MIN : Q_MAX) : s[31:0];
    return r;
  endfunction

endpackage

### sv/tss_div.sv
// ----------------------------------------------------------------------------
// tss_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tss_div #(
  parameter int NW = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [31:0]   den,
  output logic [NW-1:0] quot,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [31:0]   rem;
  logic [31:0]   dvs;
  logic [CW-1:0] cnt;
  logic          run;
  logic [32:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem, quot[NW-1]};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= den;
      quot <= num;
    end else if (run) begin
      rem  <= ge ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
      quot <= {quot[NW-2:0], ge};
    end
  end

endmodule

### sv/tss_datapath.sv
// ----------------------------------------------------------------------------
// tss_datapath
// Coefficient storage, shared multiplier, subtractors, dividers and result word.
// ----------------------------------------------------------------------------
module tss_datapath #(
  parameter int MAX_ROWS      = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tss_pkg::cmd_t               cmd,
  output tss_pkg::stat_t              stat,
  input  logic                        cfg_we,
  input  logic [tss_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic signed [31:0]          sub_diag,
  input  logic signed [31:0]          main_diag,
  input  logic signed [31:0]          super_diag,
  input  logic signed [31:0]          rhs,
  output logic                        result_strobe,
  output logic [tss_pkg::IDX_W-1:0]   row_index,
  output logic signed [31:0]          solution,
  output logic                        last_out,
  output logic                        overflow
);

  localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int NW = 32 + FRACTION_BITS;

  logic signed [31:0] mu [MAX_ROWS];
  logic signed [31:0] mr [MAX_ROWS];
  logic signed [31:0] mu_q, mr_q;

  logic signed [31:0] a_r, b_r, c_r, d_r;
  logic signed [31:0] prev_u, prev_r, x_r;
  logic signed [31:0] den_r, numer_r;
  logic signed [63:0] prod;
  logic [tss_pkg::CFG_W-1:0] min_den;
  logic               sat;
  logic               neg_u, neg_r;

  logic [IW-1:0]      addr;
  logic signed [63:0] shifted;
  logic               psat;
  logic signed [31:0] pval;
  tss_pkg::sat_t      s_den, s_num, s_bs;

  logic [tss_pkg::CFG_W-1:0] guard;
  logic [32:0]        mag;
  logic               den_neg;
  logic [31:0]        den_mag;
  logic [31:0]        cmag, nmag;
  logic [NW-1:0]      qu, qr;
  logic               u_done, r_done;
  logic               su, sr;
  logic signed [31:0] vu, vr;
  logic               div_go;

  assign addr    = cmd.addr[IW-1:0];
  assign shifted = prod >>> FRACTION_BITS;
  assign psat    = !((&shifted[63:31]) || !(|shifted[63:31]));
  assign pval    = psat ? (shifted[63] ? tss_pkg::Q_MIN : tss_pkg::Q_MAX) : shifted[31:0];
  assign s_den   = tss_pkg::sub_sat(b_r, pval);
  assign s_num   = tss_pkg::sub_sat(d_r, pval);
  assign s_bs    = tss_pkg::sub_sat(mr_q, pval);

  // pivot guard
  assign guard   = (min_den == '0) ? tss_pkg::CFG_W'(1) : min_den;
  assign mag     = den_r[31] ? 33'(-{den_r[31], den_r}) : {1'b0, den_r};
  assign den_neg = (mag < 33'(guard)) ? 1'b0 : den_r[31];
  assign den_mag = (mag < 33'(guard)) ? 32'(guard) : mag[31:0];
  assign cmag    = c_r[31] ? 32'(-c_r) : c_r;
  assign nmag    = numer_r[31] ? 32'(-numer_r) : numer_r;
  assign div_go  = (cmd.op == tss_pkg::OP_DIV);

  tss_div #(.NW(NW)) u_div_u (
    .clk(clk), .rst(rst), .start(div_go), .num({cmag, {FRACTION_BITS{1'b0}}}),
    .den(den_mag), .quot(qu), .done(u_done)
  );

  tss_div #(.NW(NW)) u_div_r (
    .clk(clk), .rst(rst), .start(div_go), .num({nmag, {FRACTION_BITS{1'b0}}}),
    .den(den_mag), .quot(qr), .done(r_done)
  );

  assign stat.div_done = u_done & r_done;

  // signed saturation of quotient magnitudes
  always_comb begin
    if (!neg_u) begin
      su = |qu[NW-1:31];
      vu = su ? tss_pkg::Q_MAX : qu[31:0];
    end else begin
      su = (|qu[NW-1:32]) || (qu[31] && (|qu[30:0]));
      vu = su ? tss_pkg::Q_MIN : 32'(-qu[31:0]);
    end
    if (!neg_r) begin
      sr = |qr[NW-1:31];
      vr = sr ? tss_pkg::Q_MAX : qr[31:0];
    end else begin
      sr = (|qr[NW-1:32]) || (qr[31] && (|qr[30:0]));
      vr = sr ? tss_pkg::Q_MIN : 32'(-qr[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_den       <= tss_pkg::CFG_W'(1);
      sat           <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_den <= cfg_wdata;
      end
      result_strobe <= (cmd.op == tss_pkg::OP_EM_OUT);
      unique case (cmd.op)
        tss_pkg::OP_SUB_U:  sat <= sat | psat | s_den.sat;
        tss_pkg::OP_SUB_R:  sat <= sat | psat | s_num.sat;
        tss_pkg::OP_BS_SUB: sat <= sat | psat | s_bs.sat;
        tss_pkg::OP_WRITE:  sat <= sat | sr | (su & !cmd.last);
        tss_pkg::OP_EM_OUT: if (cmd.addr == '0) sat <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tss_pkg::OP_LOAD: begin
        a_r <= sub_diag;
        b_r <= main_diag;
        c_r <= super_diag;
        d_r <= rhs;
      end
      tss_pkg::OP_ROW0: begin
        den_r   <= b_r;
        numer_r <= d_r;
      end
      tss_pkg::OP_MUL_U:  prod <= a_r * prev_u;
      tss_pkg::OP_SUB_U:  den_r <= s_den.val;
      tss_pkg::OP_MUL_R:  prod <= a_r * prev_r;
      tss_pkg::OP_SUB_R:  numer_r <= s_num.val;
      tss_pkg::OP_DIV: begin
        neg_u <= c_r[31] ^ den_neg;
        neg_r <= numer_r[31] ^ den_neg;
      end
      tss_pkg::OP_WRITE: begin
        mu[addr] <= cmd.last ? 32'sd0 : vu;
        mr[addr] <= vr;
        prev_u   <= cmd.last ? 32'sd0 : vu;
        prev_r   <= vr;
        x_r      <= vr;
      end
      tss_pkg::OP_BS_RD: begin
        mu_q <= mu[addr];
        mr_q <= mr[addr];
      end
      tss_pkg::OP_BS_MUL: prod <= mu_q * x_r;
      tss_pkg::OP_BS_SUB: begin
        mr[addr] <= s_bs.val;
        x_r      <= s_bs.val;
      end
      tss_pkg::OP_EM_RD:  mr_q <= mr[addr];
      tss_pkg::OP_EM_OUT: begin
        row_index <= cmd.addr;
        solution  <= mr_q;
        last_out  <= (cmd.addr == '0);
        overflow  <= sat;
      end
      default: ;
    endcase
  end

endmodule

### sv/tss_ctrl.sv
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: forward elimination per row, back substitution, emission.
// ----------------------------------------------------------------------------
module tss_ctrl #(
  parameter int MAX_ROWS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           last_row,
  input  tss_pkg::stat_t stat,
  output logic           busy,
  output tss_pkg::cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_ROW0   = 13'b0000000000010,
    S_MUL_U  = 13'b0000000000100,
    S_SUB_U  = 13'b0000000001000,
    S_MUL_R  = 13'b0000000010000,
    S_SUB_R  = 13'b0000000100000,
    S_DIV    = 13'b0000001000000,
    S_WAIT   = 13'b0000010000000,
    S_WRITE  = 13'b0000100000000,
    S_BS_RD  = 13'b0001000000000,
    S_BS_MUL = 13'b0010000000000,
    S_BS_SUB = 13'b0100000000000,
    S_EM_RD  = 13'b1000000000000
  } state_t;

  localparam logic [tss_pkg::IDX_W-1:0] TOP = tss_pkg::IDX_W'(MAX_ROWS - 1);

  state_t state, state_next;
  logic [tss_pkg::IDX_W-1:0] row_count, row_count_next;
  logic [tss_pkg::IDX_W-1:0] k, k_next;
  logic last_r, last_r_next;
  logic em_out, em_out_next;

  assign busy = (state != S_IDLE) || em_out;

  always_comb begin
    state_next     = state;
    row_count_next = row_count;
    k_next         = k;
    last_r_next    = last_r;
    em_out_next    = 1'b0;
    cmd.op         = tss_pkg::OP_NONE;
    cmd.addr       = k;
    cmd.last       = last_r;
    if (em_out) begin
      cmd.op = tss_pkg::OP_EM_OUT;
      if (k == '0) begin
        row_count_next = '0;
        state_next     = S_IDLE;
      end else begin
        k_next     = k - 1'b1;
        state_next = S_EM_RD;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd.op      = tss_pkg::OP_LOAD;
            last_r_next = last_row || (row_count == TOP);
            state_next  = (row_count == '0) ? S_ROW0 : S_MUL_U;
          end
        end
        S_ROW0: begin
          cmd.op     = tss_pkg::OP_ROW0;
          state_next = S_DIV;
        end
        S_MUL_U: begin
          cmd.op     = tss_pkg::OP_MUL_U;
          state_next = S_SUB_U;
        end
        S_SUB_U: begin
          cmd.op     = tss_pkg::OP_SUB_U;
          state_next = S_MUL_R;
        end
        S_MUL_R: begin
          cmd.op     = tss_pkg::OP_MUL_R;
          state_next = S_SUB_R;
        end
        S_SUB_R: begin
          cmd.op     = tss_pkg::OP_SUB_R;
          state_next = S_DIV;
        end
        S_DIV: begin
          cmd.op     = tss_pkg::OP_DIV;
          state_next = S_WAIT;
        end
        S_WAIT: begin
          if (stat.div_done) state_next = S_WRITE;
        end
        S_WRITE: begin
          cmd.op   = tss_pkg::OP_WRITE;
          cmd.addr = row_count;
          if (!last_r) begin
            row_count_next = row_count + 1'b1;
            state_next     = S_IDLE;
          end else if (row_count == '0) begin
            k_next     = '0;
            state_next = S_EM_RD;
          end else begin
            k_next     = row_count - 1'b1;
            state_next = S_BS_RD;
          end
        end
        S_BS_RD: begin
          cmd.op     = tss_pkg::OP_BS_RD;
          state_next = S_BS_MUL;
        end
        S_BS_MUL: begin
          cmd.op     = tss_pkg::OP_BS_MUL;
          state_next = S_BS_SUB;
        end
        S_BS_SUB: begin
          cmd.op = tss_pkg::OP_BS_SUB;
          if (k == '0) begin
            k_next     = row_count;
            state_next = S_EM_RD;
          end else begin
            k_next     = k - 1'b1;
            state_next = S_BS_RD;
          end
        end
        S_EM_RD: begin
          cmd.op      = tss_pkg::OP_EM_RD;
          em_out_next = 1'b1;
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_count <= '0;
      k         <= '0;
      last_r    <= 1'b0;
      em_out    <= 1'b0;
    end else begin
      state     <= state_next;
      row_count <= row_count_next;
      k         <= k_next;
      last_r    <= last_r_next;
      em_out    <= em_out_next;
    end
  end

endmodule

### sv/tridiagonal_system_solver_unit.sv
// ----------------------------------------------------------------------------
// tridiagonal_system_solver_unit
// Thomas-algorithm tridiagonal solver, signed fixed point, one row per word.
// ----------------------------------------------------------------------------
// channel  | handshake          | words
// rows in  | start / busy       | sub_diag, main_diag, super_diag, rhs, last_row
// results  | result_strobe      | row_index, solution, last_out, overflow
// config   | cfg_we             | cfg_wdata (min_denominator)
//
// Each row waits on the bit-serial dividers; row 0 passes through S_ROW0 in
// place of the multiply and subtract states. The last row adds a read, multiply
// and subtract per back-substitution step and a read and output per result.
// Synchronous active-high reset; no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver_unit #(
  parameter int MAX_ROWS      = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [31:0]        sub_diag,
  input  logic signed [31:0]        main_diag,
  input  logic signed [31:0]        super_diag,
  input  logic signed [31:0]        rhs,
  input  logic                      last_row,
  input  logic                      cfg_we,
  input  logic [16:0]               cfg_wdata,
  output logic                      result_strobe,
  output logic [5:0]                row_index,
  output logic signed [31:0]        solution,
  output logic                      last_out,
  output logic                      overflow
);

  tss_pkg::cmd_t  cmd;
  tss_pkg::stat_t stat;

  tss_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last_row(last_row),
    .stat(stat), .busy(busy), .cmd(cmd)
  );

  tss_datapath #(.MAX_ROWS(MAX_ROWS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .sub_diag(sub_diag), .main_diag(main_diag), .super_diag(super_diag), .rhs(rhs),
    .result_strobe(result_strobe), .row_index(row_index), .solution(solution),
    .last_out(last_out), .overflow(overflow)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Thomas tridiagonal solver: a directed table,
// then random systems of random size, checked against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAXR = 64;
  localparam int FB   = 16;

  typedef struct packed {
    logic [5:0]         idx;
    logic signed [31:0] sol;
    logic               lst;
    logic               ovf;
  } soln_t;

  typedef struct packed {
    logic               do_cfg;
    logic [16:0]        cfgv;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic               lst;
    logic               chk;
    logic signed [31:0] xsol;
    logic               xovf;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst, start, busy, last_row, cfg_we;
  logic signed [31:0] sub_diag, main_diag, super_diag, rhs;
  logic [16:0] cfg_wdata;
  logic result_strobe, last_out, overflow;
  logic [5:0] row_index;
  logic signed [31:0] solution;

  logic signed [31:0] upper_mem [MAXR];
  logic signed [31:0] rhs_mem [MAXR];
  int unsigned rows_held;
  logic sat_seen;
  logic [16:0] pivot_floor;
  soln_t soln_q [$];
  int errors = 0, n_words = 0, n_results = 0, n_systems = 0, n_cfg = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tridiagonal_system_solver_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sub_diag(sub_diag), .main_diag(main_diag), .super_diag(super_diag),
    .rhs(rhs), .last_row(last_row), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .result_strobe(result_strobe), .row_index(row_index), .solution(solution),
    .last_out(last_out), .overflow(overflow)
  );

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return tss_pkg::Q_MAX;
    end
    if (v < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return tss_pkg::Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] p,
                                                input logic signed [31:0] q);
    logic signed [63:0] wp, wq;
    wp = p;
    wq = q;
    return sat32((wp * wq) >>> FB);
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] p,
                                                input logic signed [31:0] q);
    logic signed [63:0] wp, wq;
    wp = p;
    wq = q;
    return sat32(wp - wq);
  endfunction

  function automatic logic signed [31:0] fx_div(input logic signed [31:0] n,
                                                input logic signed [63:0] den);
    logic signed [63:0] w;
    w = n;
    w = w <<< FB;
    return sat32(w / den);
  endfunction

  // forward elimination per word; back substitution on the closing row
  function automatic void eliminate_row(input logic signed [31:0] a, b, c, d,
                                        input logic lst);
    int unsigned i;
    int n;
    logic fin;
    logic signed [31:0] den32, numer;
    logic signed [63:0] den, mag, guard;
    logic signed [31:0] x [MAXR];
    soln_t r;
    i = (rows_held >= MAXR) ? MAXR - 1 : rows_held;
    fin = lst || (i + 1 >= MAXR);
    if (i == 0) begin
      den32 = b;
      numer = d;
    end else begin
      den32 = fx_sub(b, fx_mul(a, upper_mem[i-1]));
      numer = fx_sub(d, fx_mul(a, rhs_mem[i-1]));
    end
    guard = (pivot_floor == 0) ? 64'sd1 : 64'(pivot_floor);
    den = den32;
    mag = (den < 0) ? -den : den;
    if (mag < guard) den = guard;
    upper_mem[i] = fin ? 32'sd0 : fx_div(c, den);
    rhs_mem[i] = fx_div(numer, den);
    if (!fin) begin
      rows_held = i + 1;
      return;
    end
    n = i + 1;
    x[n-1] = rhs_mem[n-1];
    for (int k = n - 2; k >= 0; k--)
      x[k] = fx_sub(rhs_mem[k], fx_mul(upper_mem[k], x[k+1]));
    for (int k = n - 1; k >= 0; k--) begin
      r.idx = k[5:0];
      r.sol = x[k];
      r.lst = (k == 0);
      r.ovf = sat_seen;
      soln_q.push_back(r);
    end
    rows_held = 0;
    sat_seen = 1'b0;
    n_systems++;
  endfunction

  always @(negedge clk) begin
    soln_t e;
    if (!rst && result_strobe) begin
      n_results++;
      if (soln_q.size() == 0) begin
        $error("unexpected word: row_index %0d solution %h", row_index, solution);
        errors++;
      end else begin
        e = soln_q.pop_front();
        if (row_index !== e.idx) begin
          $error("row_index exp %0d got %0d", e.idx, row_index);
          errors++;
        end
        if (solution !== e.sol) begin
          $error("solution exp %h got %h", e.sol, solution);
          errors++;
        end
        if (last_out !== e.lst) begin
          $error("last_out exp %b got %b", e.lst, last_out);
          errors++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow exp %b got %b", e.ovf, overflow);
          errors++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // called at a rising edge; returns at the edge that takes the word, or after a random gap with start low
  task automatic send_row(input logic signed [31:0] a, b, c, d, input logic lst);
    logic bz;
    int g;
    sub_diag <= a;
    main_diag <= b;
    super_diag <= c;
    rhs <= d;
    last_row <= lst;
    start <= 1'b1;
    do begin
      @(negedge clk);
      bz = busy;
      @(posedge clk);
    end while (bz);
    eliminate_row(a, b, c, d, lst);
    n_words++;
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    wait (soln_q.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_floor(input logic [16:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    pivot_floor = v;
    n_cfg++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_sym(input int unsigned r);
    return $signed($urandom_range(0, 2 * r)) - $signed(r);
  endfunction

  function automatic logic signed [31:0] pick_edge(input logic signed [31:0] v);
    case ($urandom_range(0, 39))
      0: return tss_pkg::Q_MAX;
      1: return tss_pkg::Q_MIN;
      2: return 32'sd0;
      3: return $urandom;
      default: return v;
    endcase
  endfunction

  localparam int NDIR = 15;
  dir_row_t dir_tab [NDIR] = '{
    '{1'b0, 17'd0, 32'h0, 32'h10000, 32'h0, 32'h7fffffff, 1'b1, 1'b1, 32'h7fffffff, 1'b0},
    '{1'b0, 17'd0, 32'h0, 32'h10000, 32'h0, 32'h80000000, 1'b1, 1'b1, 32'h80000000, 1'b0},
    '{1'b0, 17'd0, 32'h0, 32'h0, 32'h0, 32'h1, 1'b1, 1'b1, 32'h10000, 1'b0},
    '{1'b0, 17'd0, 32'h0, 32'h80000000, 32'h0, 32'h7fffffff, 1'b1, 1'b1, 32'hffff0001, 1'b0},
    '{1'b0, 17'd0, 32'h0, 32'h1, 32'h0, 32'h7fffffff, 1'b1, 1'b1, 32'h7fffffff, 1'b1},
    '{1'b0, 17'd0, 32'h0, 32'hffffffff, 32'h0, 32'h7fffffff, 1'b1, 1'b1, 32'h80000000, 1'b1},
    '{1'b1, 17'd0, 32'h0, 32'h0, 32'h0, 32'h1, 1'b1, 1'b1, 32'h10000, 1'b0},
    '{1'b1, 17'h10000, 32'h0, 32'h8000, 32'h0, 32'h10000, 1'b1, 1'b1, 32'h10000, 1'b0},
    '{1'b1, 17'h1ffff, 32'h0, 32'h0, 32'h0, 32'h20000, 1'b1, 1'b1, 32'h10000, 1'b0},
    '{1'b1, 17'd1, 32'h7fffffff, 32'h20000, 32'h0, 32'h40000, 1'b1, 1'b1, 32'h20000, 1'b0},
    '{1'b0, 17'd0, 32'h0, 32'h10000, 32'h7fffffff, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{1'b0, 17'd0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1,
      1'b0, 32'h0, 1'b0},
    '{1'b0, 17'd0, 32'h0, 32'hfffc0000, 32'hffff0000, 32'h30000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{1'b0, 17'd0, 32'hffff0000, 32'h40000, 32'h10000, 32'hfffe0000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{1'b0, 17'd0, 32'h10000, 32'h30000, 32'h7fffffff, 32'h50000, 1'b1, 1'b0, 32'h0, 1'b0}
  };

  initial begin
    soln_t got;
    int sz, sys_no;
    logic signed [31:0] a, b, c, d;
    logic noisy, lst;
    rst = 1'b1;
    start = 1'b0;
    sub_diag = '0;
    main_diag = '0;
    super_diag = '0;
    rhs = '0;
    last_row = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rows_held = 0;
    sat_seen = 1'b0;
    pivot_floor = 17'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].do_cfg) write_floor(dir_tab[k].cfgv);
      send_row(dir_tab[k].a, dir_tab[k].b, dir_tab[k].c, dir_tab[k].d, dir_tab[k].lst);
      if (dir_tab[k].chk) begin
        got = soln_q[$];
        if (got.sol !== dir_tab[k].xsol) begin
          $error("table row %0d: solution exp %h got %h", k, dir_tab[k].xsol, got.sol);
          errors++;
        end
        if (got.ovf !== dir_tab[k].xovf) begin
          $error("table row %0d: overflow exp %b got %b", k, dir_tab[k].xovf, got.ovf);
          errors++;
        end
      end
    end

    sys_no = 0;
    while (n_words < 470) begin
      if (sys_no % 6 == 5) begin
        case ($urandom_range(0, 4))
          0: write_floor(17'd0);
          1: write_floor(17'd1);
          2: write_floor(17'h10000);
          3: write_floor(17'h1ffff);
          default: write_floor(17'($urandom_range(1, 65536)));
        endcase
      end
      if (sys_no == 0 || sys_no == 40 || $urandom_range(0, 49) == 0) sz = MAXR;
      else if ($urandom_range(0, 9) == 0) sz = $urandom_range(9, 63);
      else sz = $urandom_range(1, 8);
      noisy = ($urandom_range(0, 4) == 0);
      for (int r = 0; r < sz; r++) begin
        if (noisy) begin
          a = $urandom;
          b = $urandom;
          c = $urandom;
          d = $urandom;
        end else begin
          a = rnd_sym(32'h10000);
          c = rnd_sym(32'h10000);
          b = $signed($urandom_range(32'h30000, 32'h80000));
          if ($urandom_range(0, 1)) b = -b;
          d = rnd_sym(32'h640000);
          a = pick_edge(a);
          b = pick_edge(b);
          c = pick_edge(c);
          d = pick_edge(d);
        end
        lst = (r == sz - 1) && !(sz == MAXR && sys_no == 0);
        send_row(a, b, c, d, lst);
      end
      sys_no++;
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d row words in %0d systems, %0d solution words, %0d floor writes.",
             n_words, n_systems, n_results, n_cfg);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
